// ===== src/lzwd_pkg.sv =====
// Shared types and constants for the LZ window decompressor.
`timescale 1ns / 1ps
`default_nettype none

package lzwd_pkg;

  localparam int HISTORY_DEPTH_DEF = 1024;
  localparam int OFFSET_W = 11;
  localparam int LEN_W = 6;
  localparam logic [9:0] OFFSET_MASK = 10'h3FF;
  localparam logic [4:0] LEN_MASK = 5'h1F;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_HDR2,
    PH_HDR3,
    PH_FLAG,
    PH_MATCH2,
    PH_LITERAL,
    PH_FULL
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_SURPLUS,
    ERR_OFFSET
  } err_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_LENGTH,
    ST_OFFSET
  } status_t;

  typedef enum logic [1:0] {
    S_IN,
    S_RD,
    S_WR,
    S_ST
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic [1:0] status_code;
    logic       run_last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/lzwd_in_if.sv =====
// Channel interface that carries compressed stream beats.
`timescale 1ns / 1ps
`default_nettype none

interface lzwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ===== src/lzwd_out_if.sv =====
// Channel interface that carries decompressed data and status beats.
`timescale 1ns / 1ps
`default_nettype none

interface lzwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_status;
  logic [1:0] status_code;
  logic       run_last;

  modport source (output valid, output out_byte, output is_status, output status_code,
                  output run_last, input ready);
  modport sink (input valid, input out_byte, input is_status, input status_code,
                input run_last, output ready);
endinterface

`default_nettype wire

// ===== src/lzwd_ram.sv =====
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/lzwd_obuf.sv =====
// Output register that holds one result beat until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module lzwd_obuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lzwd_pkg::out_item_t item,
  output logic                push_ready,
  lzwd_out_if.source          out_ch
);
  import lzwd_pkg::*;

  logic      valid;
  out_item_t data;

  assign push_ready = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push_ready) begin
      valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      data <= item;
    end
  end

  assign out_ch.valid       = valid;
  assign out_ch.out_byte    = data.out_byte;
  assign out_ch.is_status   = data.is_status;
  assign out_ch.status_code = data.status_code;
  assign out_ch.run_last    = data.run_last;

endmodule

`default_nettype wire

// ===== src/lzwd_ctrl.sv =====
// Token decoder and copy sequencer that drives the history RAM.
`timescale 1ns / 1ps
`default_nettype none

module lzwd_ctrl #(
  parameter int HISTORY_DEPTH = lzwd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  lzwd_in_if.sink                          in_ch,
  output logic                             push,
  output lzwd_pkg::out_item_t              item,
  input  logic                             push_ready,
  output logic                             ram_we,
  output logic [$clog2(HISTORY_DEPTH)-1:0] ram_waddr,
  output logic [7:0]                       ram_wdata,
  output logic                             ram_re,
  output logic [$clog2(HISTORY_DEPTH)-1:0] ram_raddr,
  input  logic [7:0]                       ram_rdata
);
  import lzwd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  ctrl_state_t         state, state_next;
  phase_t              phase, phase_next;
  err_t                err, err_next;
  logic [31:0]         expected_length, expected_length_next;
  logic [31:0]         produced_count, produced_count_next;
  logic [7:0]          lit_rem, lit_rem_next;
  logic [7:0]          pending_flag, pending_flag_next;
  logic [AW-1:0]       wp, wp_next;
  logic [OFFSET_W-1:0] offset, offset_next;
  logic [LEN_W-1:0]    match_rem, match_rem_next;
  logic                last_flag, last_flag_next;

  logic                accept;
  logic [31:0]         produced_inc;
  logic                reach_full;
  logic                hist_ok;
  logic [AW:0]         rd_diff;
  logic [31:0]         hdr_len;
  logic [15:0]         match_word;
  logic [OFFSET_W-1:0] new_offset;
  logic                match_end;
  logic [7:0]          copy_byte;

  assign accept       = in_ch.valid && in_ch.ready;
  assign produced_inc = produced_count + 32'd1;
  assign reach_full   = produced_inc == expected_length;
  assign hist_ok      = produced_count >= 32'(offset);
  assign rd_diff      = {1'b0, wp} - (AW+1)'(offset);
  assign ram_raddr    = rd_diff[AW-1:0];
  assign hdr_len      = expected_length | (32'(in_ch.in_byte) << {phase[1:0], 3'b000});
  assign match_word   = {pending_flag, in_ch.in_byte};
  assign new_offset   = {1'b0, match_word[14:5] & OFFSET_MASK} + 11'd1;
  assign match_end    = (match_rem == 6'd1) || reach_full;
  assign copy_byte    = hist_ok ? ram_rdata : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IN;
      phase           <= PH_HDR0;
      err             <= ERR_NONE;
      expected_length <= '0;
      produced_count  <= '0;
      lit_rem         <= '0;
      pending_flag    <= '0;
      wp              <= '0;
      offset          <= '0;
      match_rem       <= '0;
      last_flag       <= 1'b0;
    end else begin
      state           <= state_next;
      phase           <= phase_next;
      err             <= err_next;
      expected_length <= expected_length_next;
      produced_count  <= produced_count_next;
      lit_rem         <= lit_rem_next;
      pending_flag    <= pending_flag_next;
      wp              <= wp_next;
      offset          <= offset_next;
      match_rem       <= match_rem_next;
      last_flag       <= last_flag_next;
    end
  end

  always_comb begin
    state_next           = state;
    phase_next           = phase;
    err_next             = err;
    expected_length_next = expected_length;
    produced_count_next  = produced_count;
    lit_rem_next         = lit_rem;
    pending_flag_next    = pending_flag;
    wp_next              = wp;
    offset_next          = offset;
    match_rem_next       = match_rem;
    last_flag_next       = last_flag;
    in_ch.ready          = 1'b0;
    push                 = 1'b0;
    item                 = '0;
    ram_we               = 1'b0;
    ram_re               = 1'b0;
    ram_waddr            = wp;
    ram_wdata            = in_ch.in_byte;

    case (state)
      S_IN: begin
        in_ch.ready = push_ready;
        if (accept) begin
          last_flag_next = in_ch.in_last;
          case (phase)
            PH_HDR0, PH_HDR1, PH_HDR2: begin
              expected_length_next = hdr_len;
              phase_next           = phase_t'(phase + 3'd1);
            end
            PH_HDR3: begin
              expected_length_next = hdr_len;
              phase_next           = (hdr_len == 32'd0) ? PH_FULL : PH_FLAG;
            end
            PH_FLAG: begin
              if (in_ch.in_byte[7]) begin
                pending_flag_next = in_ch.in_byte;
                phase_next        = PH_MATCH2;
              end else begin
                lit_rem_next = in_ch.in_byte + 8'd1;
                phase_next   = PH_LITERAL;
              end
            end
            PH_MATCH2: begin
              offset_next       = new_offset;
              match_rem_next    = {1'b0, match_word[4:0] & LEN_MASK} + 6'd1;
              pending_flag_next = '0;
              if (32'(new_offset) > produced_count) begin
                err_next = ERR_OFFSET;
              end
              state_next = S_RD;
            end
            PH_LITERAL: begin
              push                = 1'b1;
              item.out_byte       = in_ch.in_byte;
              item.run_last       = !in_ch.in_last;
              ram_we              = 1'b1;
              wp_next             = wp + AW'(1);
              produced_count_next = produced_inc;
              lit_rem_next        = lit_rem - 8'd1;
              if (reach_full) begin
                phase_next   = PH_FULL;
                lit_rem_next = '0;
              end else if (lit_rem == 8'd1) begin
                phase_next = PH_FLAG;
              end
            end
            default: begin
              if (err == ERR_NONE) begin
                err_next = ERR_SURPLUS;
              end
            end
          endcase
          if (in_ch.in_last && phase != PH_MATCH2) begin
            state_next = S_ST;
          end
        end
      end
      S_RD: begin
        ram_re     = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        if (push_ready) begin
          push                = 1'b1;
          item.out_byte       = copy_byte;
          item.run_last       = match_end && !last_flag;
          ram_we              = 1'b1;
          ram_wdata           = copy_byte;
          wp_next             = wp + AW'(1);
          produced_count_next = produced_inc;
          match_rem_next      = match_rem - 6'd1;
          if (match_end) begin
            phase_next = reach_full ? PH_FULL : PH_FLAG;
            state_next = last_flag ? S_ST : S_IN;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_ST: begin
        if (push_ready) begin
          push           = 1'b1;
          item.is_status = 1'b1;
          item.run_last  = 1'b1;
          if (err == ERR_OFFSET) begin
            item.status_code = ST_OFFSET;
          end else if (phase inside {PH_FLAG, PH_MATCH2, PH_LITERAL, PH_FULL} &&
                       err == ERR_NONE && produced_count == expected_length) begin
            item.status_code = ST_OK;
          end else begin
            item.status_code = ST_LENGTH;
          end
          phase_next           = PH_HDR0;
          err_next             = ERR_NONE;
          expected_length_next = '0;
          produced_count_next  = '0;
          lit_rem_next         = '0;
          pending_flag_next    = '0;
          wp_next              = '0;
          state_next           = S_IN;
        end
      end
      default: begin
        state_next = S_IN;
      end
    endcase
  end

`ifndef SYNTH
  a_we_emits: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> push && !item.is_status)
    else $error("History write without a matching data beat.");

  a_status_clears: assert property (@(posedge clk) disable iff (rst)
    (push && push_ready && item.is_status) |=> phase == PH_HDR0 && produced_count == 32'd0)
    else $error("Stream state not cleared after the status beat.");

  a_read_before_write: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> $past(state) == S_RD || $past(state) == S_WR)
    else $error("Copy write without a preceding history read.");

  a_literal_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LITERAL |-> lit_rem != 8'd0)
    else $error("Literal run active with no bytes left.");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    phase[2] |-> produced_count <= expected_length)
    else $error("Output count passed the expected length.");
`endif

endmodule

`default_nettype wire

// ===== src/lz_window_decompressor.sv =====
// Top level of the LZ window decompressor.
`timescale 1ns / 1ps
`default_nettype none

// Takes a compressed stream one beat per byte: a four-byte little-endian
// output length, then literal runs and two-byte matches that copy from a
// HISTORY_DEPTH-byte window, and returns the decompressed bytes followed by
// one status beat on the beat marked last. Every byte that a match copies is
// a read and then a write of the single history RAM, so no new input byte is
// taken while a copy runs. The history needs no clearing after reset,
// because a copy only uses bytes written earlier in the same stream.
module lz_window_decompressor #(
  parameter int HISTORY_DEPTH = lzwd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lzwd_in_if.sink    in_ch,
  lzwd_out_if.source out_ch
);
  import lzwd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic          push;
  logic          push_ready;
  out_item_t     item;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  lzwd_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .push      (push),
    .item      (item),
    .push_ready(push_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lzwd_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lzwd_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .push_ready(push_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/lz_window_decompressor_test.sv =====
// Self-checking testbench for the LZ window decompressor top level.
`timescale 1ns / 1ps

module lz_window_decompressor_test;
  import lzwd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int WINDOW = 1024;

  logic clk;
  logic rst;

  lzwd_in_if in_ch ();
  lzwd_out_if out_ch ();

  lz_window_decompressor dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fail_count;
  int unsigned quiet_cycles;

  out_item_t beats_due[$];
  logic [7:0] pkt[$];

  phase_t sw_phase;
  logic [31:0] sw_len;
  logic [31:0] sw_count;
  logic [8:0] sw_lit_left;
  logic [7:0] sw_flag;
  logic [7:0] sw_hist[WINDOW];
  logic [9:0] sw_wp;
  err_t sw_err;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_decoder();
    sw_phase = PH_HDR0;
    sw_len = '0;
    sw_count = '0;
    sw_lit_left = '0;
    sw_flag = '0;
    sw_wp = '0;
    sw_err = ERR_NONE;
  endfunction

  function automatic void push_data(input logic [7:0] b);
    out_item_t it;
    sw_hist[sw_wp] = b;
    sw_wp = sw_wp + 10'd1;
    sw_count = sw_count + 32'd1;
    it = '{out_byte: b, is_status: 1'b0, status_code: ST_OK, run_last: 1'b0};
    beats_due.push_back(it);
  endfunction

  // Works out every beat that one compressed byte will cause.
  function automatic void decode_byte(input logic [7:0] b, input logic l);
    logic [15:0] word;
    logic [10:0] ofs;
    logic [5:0] len;
    logic [31:0] start;
    logic [7:0] v;
    out_item_t it;
    int i;
    int n0;
    n0 = beats_due.size();
    if (sw_phase < PH_FLAG) begin
      sw_len = sw_len | (32'(b) << (8 * int'(sw_phase)));
      sw_phase = phase_t'(sw_phase + 3'd1);
      if (sw_phase == PH_FLAG && sw_len == 0) sw_phase = PH_FULL;
    end else if (sw_phase == PH_FLAG) begin
      if (b[7]) begin
        sw_flag = b;
        sw_phase = PH_MATCH2;
      end else begin
        sw_lit_left = {1'b0, b} + 9'd1;
        sw_phase = PH_LITERAL;
      end
    end else if (sw_phase == PH_MATCH2) begin
      word = {sw_flag, b};
      ofs = {1'b0, word[14:5]} + 11'd1;
      len = {1'b0, word[4:0]} + 6'd1;
      start = sw_count;
      if (32'(ofs) > start) sw_err = ERR_OFFSET;
      for (i = 0; i < int'(len) && sw_count < sw_len; i++) begin
        v = 8'h00;
        if (64'(start) + 64'(i) >= 64'(ofs)) v = sw_hist[sw_wp - ofs[9:0]];
        push_data(v);
      end
      sw_flag = '0;
      sw_phase = (sw_count == sw_len) ? PH_FULL : PH_FLAG;
    end else if (sw_phase == PH_LITERAL) begin
      push_data(b);
      if (sw_lit_left > 0) sw_lit_left = sw_lit_left - 9'd1;
      if (sw_count == sw_len) begin
        sw_phase = PH_FULL;
        sw_lit_left = '0;
      end else begin
        sw_phase = (sw_lit_left == 0) ? PH_FLAG : PH_LITERAL;
      end
    end else begin
      if (sw_err == ERR_NONE) sw_err = ERR_SURPLUS;
    end

    if (l) begin
      it = '{out_byte: 8'h00, is_status: 1'b1, status_code: ST_LENGTH, run_last: 1'b0};
      if (sw_err == ERR_OFFSET) it.status_code = ST_OFFSET;
      else if (sw_phase >= PH_FLAG && sw_err == ERR_NONE && sw_count == sw_len)
        it.status_code = ST_OK;
      beats_due.push_back(it);
      clear_decoder();
    end
    if (beats_due.size() > n0) begin
      it = beats_due[beats_due.size() - 1];
      it.run_last = 1'b1;
      beats_due[beats_due.size() - 1] = it;
    end
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    decode_byte(b, l);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_pkt();
    int i;
    for (i = 0; i < pkt.size(); i++) send_beat(pkt[i], i == pkt.size() - 1);
  endtask

  // Builds a stream of the given output length into pkt; bad_pct adds bad offsets.
  function automatic void build_stream(input int unsigned total, input int unsigned bad_pct,
                                       input int unsigned lit_pct);
    int unsigned made;
    int unsigned run;
    int unsigned len;
    int unsigned ofs;
    int unsigned reach;
    int unsigned i;
    logic [15:0] word;
    pkt.delete();
    for (i = 0; i < 4; i++) pkt.push_back(8'(total >> (8 * i)));
    made = 0;
    while (made < total) begin
      if (made == 0 || $urandom_range(99) < lit_pct) begin
        run = ($urandom_range(9) == 0) ? $urandom_range(128, 1) : $urandom_range(8, 1);
        if (run > total - made) run = total - made;
        pkt.push_back(8'(run - 1));
        for (i = 0; i < run; i++) pkt.push_back(8'($urandom));
        made += run;
      end else begin
        len = $urandom_range(32, 1);
        if (len > total - made && $urandom_range(3) != 0) len = total - made;
        reach = (made > WINDOW) ? WINDOW : made;
        ofs = $urandom_range(reach, 1);
        if (reach < WINDOW && $urandom_range(99) < bad_pct)
          ofs = $urandom_range(WINDOW, reach + 1);
        if (made >= WINDOW && $urandom_range(3) == 0) ofs = WINDOW;
        word = {1'b1, 10'(ofs - 1), 5'(len - 1)};
        pkt.push_back(word[15:8]);
        pkt.push_back(word[7:0]);
        made += len;
      end
    end
  endfunction

  function automatic int unsigned pick_length();
    if ($urandom_range(9) == 0) return $urandom_range(300, 41);
    return $urandom_range(40, 0);
  endfunction

  task automatic test_literal_and_match();
    pkt = '{8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h03};
    send_pkt();
  endtask

  task automatic test_zero_length();
    pkt = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_pkt();
  endtask

  task automatic test_bad_offset();
    pkt = '{8'h02, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF};
    send_pkt();
  endtask

  task automatic test_surplus_input();
    pkt = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hAA, 8'h55};
    send_pkt();
  endtask

  task automatic test_short_header();
    pkt = '{8'hFF};
    send_pkt();
  endtask

  task automatic test_random_streams(input int unsigned n_items);
    int unsigned sent;
    int unsigned kind;
    int unsigned k;
    int unsigned cnt;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        build_stream(pick_length(), 0, 40);
      end else if (kind < 80) begin
        build_stream(pick_length(), 60, 40);
      end else if (kind < 86) begin
        build_stream(pick_length(), 0, 40);
        cnt = $urandom_range(6, 1);
        for (k = 0; k < cnt && pkt.size() > 1; k++) void'(pkt.pop_back());
      end else if (kind < 91) begin
        build_stream(pick_length(), 0, 40);
        cnt = $urandom_range(4, 1);
        for (k = 0; k < cnt; k++) pkt.push_back(8'($urandom));
      end else if (kind < 95) begin
        build_stream(pick_length(), 0, 40);
        pkt[$urandom_range(pkt.size() - 1)] = 8'($urandom);
      end else begin
        cnt = $urandom_range(12, 1);
        for (k = 0; k + 1 < cnt; k++) begin
          send_beat(8'($urandom), $urandom_range(7) == 0);
          sent++;
        end
        pkt = '{8'($urandom)};
      end
      send_pkt();
      sent += pkt.size();
    end
  endtask

  // Mostly matches, so that the output passes the window size with few input beats.
  task automatic test_window_wrap();
    build_stream(1100, 0, 0);
    send_pkt();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.in_last <= 1'b0;
    rst <= 1'b1;
    fail_count = 0;
    send_idle_pct = 37;
    recv_idle_pct = 80;
    clear_decoder();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_literal_and_match();
    test_zero_length();
    test_bad_offset();
    test_surplus_input();
    test_short_header();
    test_random_streams(25);

    send_idle_pct = 80;
    recv_idle_pct = 37;
    test_random_streams(25);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_streams(25);
    test_window_wrap();

    in_ch.valid <= 1'b0;
    while (beats_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (beats_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat, expected none actual %0h/%0b/%0d/%0b", $time,
                 out_ch.out_byte, out_ch.is_status, out_ch.status_code, out_ch.run_last);
      end else begin
        want = beats_due.pop_front();
        check_field("out_byte", want.out_byte, out_ch.out_byte);
        check_field("is_status", want.is_status, out_ch.is_status);
        check_field("status_code", want.status_code, out_ch.status_code);
        check_field("run_last", want.run_last, out_ch.run_last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d beats still expected", $time,
               QUIET_LIMIT, beats_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
